FILE: rtl/core/btfs_pkg.sv
package btfs_pkg;

  localparam int OP_W        = 3;
  localparam int IDX_W       = 11;
  localparam int LIM_W       = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH_L = 3'd0,
    OP_SEARCH_R = 3'd1,
    OP_ALLOC    = 3'd2,
    OP_FREE     = 3'd3,
    OP_QUERY    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ALU_CHILD_A,
    ALU_CHILD_B,
    ALU_SIBLING,
    ALU_PARENT
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    right_first;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_VCHK,
    ST_CA,
    ST_CB,
    ST_BACK,
    ST_WRITE,
    ST_QRD,
    ST_QCHK
  } state_t;

endpackage

FILE: rtl/core/buddy_tree_free_node_search.sv
// channel | dir | tdata (low bit up)                        | tuser
// in_     | in  | node_index[10:0] depth_limit[14:11] 0[15] | operation[2:0]
// out_    | out | result_node[10:0] is_set[11] 0[15:12]     | found[0]
//
// Alloc, free and unused codes pass through ST_WRITE before the result; query passes through ST_QRD, ST_QCHK.
// Search: ST_VISIT and ST_VCHK per node visited, ST_CA and ST_CB per child pair read, ST_BACK per step
// back up; the single read port of the node bit RAM sets the pace.
// After reset a clearing pass writes every node bit to zero with in_tready low.
// One item at a time; a waiting result holds off the next accept.
module buddy_tree_free_node_search #(
  parameter int TREE_DEPTH = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [btfs_pkg::IN_TDATA_W-1:0]  in_tdata,   // node_index, depth_limit
  input  logic [btfs_pkg::OP_W-1:0]        in_tuser,   // operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [btfs_pkg::OUT_TDATA_W-1:0] out_tdata,  // result_node, is_set
  output logic [0:0]                       out_tuser   // found
);

  localparam int NW         = TREE_DEPTH + 1;
  localparam int NODE_COUNT = (1 << NW) - 1;
  localparam int LVW        = $clog2(TREE_DEPTH + 1);
  localparam int CW         = (NW > btfs_pkg::IDX_W) ? NW : btfs_pkg::IDX_W;

  btfs_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]    cur_r, cur_nxt;
  logic [LVW-1:0]   lvl_r, lvl_nxt;
  logic [LVW-1:0]   lim_r, lim_nxt;
  logic             rf_r, rf_nxt;
  logic [btfs_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [btfs_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic             abit_r, abit_nxt;
  logic [NW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [btfs_pkg::IDX_W-1:0] out_node_r, out_node_nxt;
  logic             out_set_r, out_set_nxt;

  logic             ram_we;
  logic [NW-1:0]    ram_waddr;
  logic             ram_wdata;
  logic [NW-1:0]    ram_raddr;
  logic             ram_rdata;

  btfs_pkg::alu_req_t alu_req;
  logic [NW-1:0]      alu_out;

  logic [CW-1:0]    idx_ext;
  logic [CW-1:0]    cur_ext;
  logic [CW-1:0]    alu_ext;
  logic             idx_ok;
  logic [NW-1:0]    idx_addr;
  logic             accept;
  logic [btfs_pkg::IDX_W-1:0] in_idx;
  logic [btfs_pkg::LIM_W-1:0] in_lim;

  assign in_idx   = in_tdata[btfs_pkg::IDX_W-1:0];
  assign in_lim   = in_tdata[btfs_pkg::IDX_W +: btfs_pkg::LIM_W];
  assign idx_ext  = CW'(idx_r);
  assign cur_ext  = CW'(cur_r);
  assign alu_ext  = CW'(alu_out);
  assign idx_ok   = idx_ext < CW'(NODE_COUNT);
  assign idx_addr = idx_ext[NW-1:0];

  assign in_tready = (state_r == btfs_pkg::ST_IDLE) && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  btfs_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_bits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  btfs_node_alu #(
    .NW (NW)
  ) u_alu (
    .req    (alu_req),
    .node   (cur_r),
    .result (alu_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= btfs_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    lvl_r       <= lvl_nxt;
    lim_r       <= lim_nxt;
    rf_r        <= rf_nxt;
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    abit_r      <= abit_nxt;
    out_found_r <= out_found_nxt;
    out_node_r  <= out_node_nxt;
    out_set_r   <= out_set_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    lvl_nxt        = lvl_r;
    lim_nxt        = lim_r;
    rf_nxt         = rf_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    abit_nxt       = abit_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_node_nxt   = out_node_r;
    out_set_nxt    = out_set_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_addr;
    ram_wdata      = 1'b0;
    ram_raddr      = cur_r;
    alu_req.op          = btfs_pkg::ALU_CHILD_A;
    alu_req.right_first = rf_r;

    case (state_r)
      btfs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == NW'(NODE_COUNT - 1)) begin
          state_nxt = btfs_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + NW'(1);
        end
      end

      btfs_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_tuser;
          idx_nxt = in_idx;
          cur_nxt = '0;
          lvl_nxt = '0;
          rf_nxt  = (in_tuser == btfs_pkg::OP_SEARCH_R);
          if (32'(in_lim) > TREE_DEPTH) begin
            lim_nxt = LVW'(TREE_DEPTH);
          end else begin
            lim_nxt = LVW'(in_lim);
          end
          case (in_tuser)
            btfs_pkg::OP_SEARCH_L,
            btfs_pkg::OP_SEARCH_R: state_nxt = btfs_pkg::ST_VISIT;
            btfs_pkg::OP_QUERY:    state_nxt = btfs_pkg::ST_QRD;
            default:               state_nxt = btfs_pkg::ST_WRITE;
          endcase
        end
      end

      btfs_pkg::ST_VISIT: begin
        ram_raddr = cur_r;
        state_nxt = btfs_pkg::ST_VCHK;
      end

      btfs_pkg::ST_VCHK: begin
        alu_req.op = btfs_pkg::ALU_CHILD_A;
        ram_raddr  = alu_out;
        if (!ram_rdata) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          out_node_nxt   = cur_ext[btfs_pkg::IDX_W-1:0];
          out_set_nxt    = 1'b0;
          state_nxt      = btfs_pkg::ST_IDLE;
        end else if (lvl_r < lim_r) begin
          state_nxt = btfs_pkg::ST_CA;
        end else begin
          state_nxt = btfs_pkg::ST_BACK;
        end
      end

      btfs_pkg::ST_CA: begin
        abit_nxt   = ram_rdata;
        alu_req.op = btfs_pkg::ALU_CHILD_B;
        ram_raddr  = alu_out;
        state_nxt  = btfs_pkg::ST_CB;
      end

      btfs_pkg::ST_CB: begin
        alu_req.op = btfs_pkg::ALU_CHILD_A;
        if (!abit_r && !ram_rdata) begin
          // set node over two free children: allocated leaf
          state_nxt = btfs_pkg::ST_BACK;
        end else if (!abit_r) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          out_node_nxt   = alu_ext[btfs_pkg::IDX_W-1:0];
          out_set_nxt    = 1'b0;
          state_nxt      = btfs_pkg::ST_IDLE;
        end else begin
          cur_nxt   = alu_out;
          lvl_nxt   = lvl_r + LVW'(1);
          state_nxt = btfs_pkg::ST_VISIT;
        end
      end

      btfs_pkg::ST_BACK: begin
        if (cur_r == '0) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = 1'b0;
          out_node_nxt   = '0;
          out_set_nxt    = 1'b0;
          state_nxt      = btfs_pkg::ST_IDLE;
        end else if (cur_r[0] ^ rf_r) begin
          // first child done, try its sibling
          alu_req.op = btfs_pkg::ALU_SIBLING;
          cur_nxt    = alu_out;
          state_nxt  = btfs_pkg::ST_VISIT;
        end else begin
          alu_req.op = btfs_pkg::ALU_PARENT;
          cur_nxt    = alu_out;
          lvl_nxt    = lvl_r - LVW'(1);
        end
      end

      btfs_pkg::ST_WRITE: begin
        ram_we    = idx_ok && (op_r == btfs_pkg::OP_ALLOC || op_r == btfs_pkg::OP_FREE);
        ram_waddr = idx_addr;
        ram_wdata = (op_r == btfs_pkg::OP_ALLOC);
        out_tvalid_nxt = 1'b1;
        out_found_nxt  = 1'b1;
        out_node_nxt   = '0;
        out_set_nxt    = 1'b0;
        state_nxt      = btfs_pkg::ST_IDLE;
      end

      btfs_pkg::ST_QRD: begin
        ram_raddr = idx_addr;
        state_nxt = btfs_pkg::ST_QCHK;
      end

      btfs_pkg::ST_QCHK: begin
        out_tvalid_nxt = 1'b1;
        out_found_nxt  = 1'b1;
        out_node_nxt   = '0;
        out_set_nxt    = idx_ok && ram_rdata;
        state_nxt      = btfs_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = btfs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{(btfs_pkg::OUT_TDATA_W - btfs_pkg::IDX_W - 1){1'b0}},
                       out_set_r, out_node_r};

endmodule

FILE: rtl/core/btfs_ram.sv
module btfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/btfs_node_alu.sv
module btfs_node_alu #(
  parameter int NW = 11
) (
  input  btfs_pkg::alu_req_t req,
  input  logic [NW-1:0]      node,
  output logic [NW-1:0]      result
);

  logic [NW-1:0] base;
  logic [NW-1:0] addend;
  logic [NW-1:0] sum;

  always_comb begin
    base   = node;
    addend = '1;
    case (req.op)
      btfs_pkg::ALU_CHILD_A: begin
        base   = {node[NW-2:0], 1'b0};
        addend = req.right_first ? NW'(2) : NW'(1);
      end
      btfs_pkg::ALU_CHILD_B: begin
        base   = {node[NW-2:0], 1'b0};
        addend = req.right_first ? NW'(1) : NW'(2);
      end
      btfs_pkg::ALU_SIBLING: begin
        addend = node[0] ? NW'(1) : '1;
      end
      btfs_pkg::ALU_PARENT: begin
        addend = '1;
      end
      default: begin
        addend = '1;
      end
    endcase
    sum = base + addend;
    result = (req.op == btfs_pkg::ALU_PARENT) ? (sum >> 1) : sum;
  end

endmodule

FILE: rtl/core/btfs_checker.sv
module btfs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [btfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);

  // one item in flight: no accept while a result is stuck
  a_no_accept_over_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tready)
    else $error("input ready while result stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result shown the cycle after accept");

  a_miss_zero_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[btfs_pkg::IDX_W-1:0] == '0)
    else $error("not found but node nonzero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind buddy_tree_free_node_search btfs_checker u_btfs_checker (.*);

FILE: tb/sv/tb.sv
module tb;

  localparam int TREE_DEPTH   = 10;
  localparam int NODE_COUNT   = (1 << (TREE_DEPTH + 1)) - 1;
  localparam int STALL_CYCLES = 300;
  localparam int OP_W         = btfs_pkg::OP_W;
  localparam int IDX_W        = btfs_pkg::IDX_W;
  localparam int LIM_W        = btfs_pkg::LIM_W;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] node;
    logic             is_set;
  } result_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [btfs_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]                  in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [btfs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]                       out_tuser;

  bit      tree_bits [NODE_COUNT];
  result_t expected_results [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      stall_requests = 0;
  int      stalls_done = 0;

  buddy_tree_free_node_search #(.TREE_DEPTH(TREE_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic bit node_set(int n);
    return (n >= 0 && n < NODE_COUNT) ? tree_bits[n] : 1'b0;
  endfunction

  function automatic int node_level(int n);
    int lvl;
    lvl = 0;
    while (n > 0) begin
      n = (n - 1) / 2;
      lvl++;
    end
    return lvl;
  endfunction

  // preorder walk; a set node with both children clear is an allocated leaf
  function automatic bit find_free(int lim, bit right_first, output int hit);
    int pend_node [$];
    int pend_lvl [$];
    int n, lvl, a, b;
    hit = 0;
    pend_node.push_back(0);
    pend_lvl.push_back(0);
    while (pend_node.size() > 0) begin
      n = pend_node.pop_back();
      lvl = pend_lvl.pop_back();
      if (!node_set(n)) begin
        hit = n;
        return 1'b1;
      end
      if (lvl < lim) begin
        a = 2 * n + (right_first ? 2 : 1);
        b = 2 * n + (right_first ? 1 : 2);
        if (node_set(a) || node_set(b)) begin
          pend_node.push_back(b);
          pend_lvl.push_back(lvl + 1);
          pend_node.push_back(a);
          pend_lvl.push_back(lvl + 1);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t buddy_op_result(logic [OP_W-1:0] op, int idx, int lim);
    result_t r;
    int      hit;
    r.found = 1'b1;
    r.node = '0;
    r.is_set = 1'b0;
    idx = idx & ((1 << IDX_W) - 1);
    lim = lim & ((1 << LIM_W) - 1);
    if (lim > TREE_DEPTH) lim = TREE_DEPTH;
    case (op)
      btfs_pkg::OP_SEARCH_L, btfs_pkg::OP_SEARCH_R: begin
        r.found = find_free(lim, op == btfs_pkg::OP_SEARCH_R, hit);
        r.node = r.found ? IDX_W'(hit) : '0;
      end
      btfs_pkg::OP_ALLOC: begin
        if (idx < NODE_COUNT) tree_bits[idx] = 1'b1;
      end
      btfs_pkg::OP_FREE: begin
        if (idx < NODE_COUNT) tree_bits[idx] = 1'b0;
      end
      btfs_pkg::OP_QUERY: r.is_set = node_set(idx);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, int idx, int lim);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, LIM_W'(lim), IDX_W'(idx)};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(buddy_op_result(op, idx, lim));
    items_sent++;
  endtask

  // receiver: random backpressure plus on-demand long hold-off
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_done) begin
        hold = STALL_CYCLES;
        stalls_done = stall_requests;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: found %0d result_node %0d is_set %0d",
               out_tuser[0], out_tdata[IDX_W-1:0], out_tdata[IDX_W]);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tdata[IDX_W-1:0] !== want.node) begin
          $error("result_node: expected %0d, got %0d", want.node, out_tdata[IDX_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[IDX_W] !== want.is_set) begin
          $error("is_set: expected %0d, got %0d", want.is_set, out_tdata[IDX_W]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_item(btfs_pkg::OP_QUERY, 0, 0);
    send_item(btfs_pkg::OP_QUERY, NODE_COUNT - 1, 0);
    send_item(btfs_pkg::OP_ALLOC, NODE_COUNT, 0);
    send_item(btfs_pkg::OP_QUERY, NODE_COUNT, 15);
    send_item(btfs_pkg::OP_FREE, NODE_COUNT, 0);
    send_item(btfs_pkg::OP_SEARCH_L, 0, 0);
    send_item(btfs_pkg::OP_SEARCH_R, 0, 15);
    send_item(btfs_pkg::OP_ALLOC, 0, 0);
    send_item(btfs_pkg::OP_SEARCH_L, 0, TREE_DEPTH);
    send_item(btfs_pkg::OP_QUERY, 0, 0);
    send_item(btfs_pkg::OP_ALLOC, 1, 0);
    send_item(btfs_pkg::OP_SEARCH_L, 0, 15);
    send_item(btfs_pkg::OP_SEARCH_R, 0, TREE_DEPTH);
    send_item(btfs_pkg::OP_SEARCH_L, 0, 0);
    send_item(btfs_pkg::OP_ALLOC, 2, 0);
    send_item(btfs_pkg::OP_SEARCH_R, 0, 1);
    for (int c = btfs_pkg::OP_QUERY + 1; c < (1 << OP_W); c++)
      send_item(OP_W'(c), NODE_COUNT, 15);
    send_item(btfs_pkg::OP_ALLOC, NODE_COUNT - 1, 0);
    send_item(btfs_pkg::OP_QUERY, NODE_COUNT - 1, 0);
    send_item(btfs_pkg::OP_SEARCH_R, NODE_COUNT, TREE_DEPTH);
    send_item(btfs_pkg::OP_FREE, NODE_COUNT - 1, 0);
    send_item(btfs_pkg::OP_FREE, 2, 0);
    send_item(btfs_pkg::OP_FREE, 1, 0);
    send_item(btfs_pkg::OP_FREE, 0, 0);
  endtask

  // receiver holds off while items keep coming, so the input must stall
  task automatic test_backpressure();
    int n;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_requests++;
    for (int k = 0; k < 12; k++) begin
      n = $urandom_range(0, NODE_COUNT - 1);
      send_item(btfs_pkg::OP_ALLOC, n, 0);
      send_item(btfs_pkg::OP_QUERY, n, 0);
      send_item(OP_W'($urandom_range(btfs_pkg::OP_SEARCH_L, btfs_pkg::OP_SEARCH_R)), 0,
                $urandom_range(0, 15));
      send_item(btfs_pkg::OP_FREE, n, 0);
    end
  endtask

  // buddy allocator traffic: search then split down and allocate, free with
  // merging of clear buddies, plus queries and random noise
  task automatic test_buddy_traffic(int tx_pct, int rx_pct, int count);
    int goal, pick, lim, target, hit, lvl, n, start, parent, sib;
    bit rf;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        rf = 1'($urandom_range(1));
        lim = ($urandom_range(99) < 80) ? $urandom_range(0, 7) : $urandom_range(8, 15);
        target = (lim > TREE_DEPTH) ? TREE_DEPTH : lim;
        send_item(rf ? btfs_pkg::OP_SEARCH_R : btfs_pkg::OP_SEARCH_L,
                  $urandom_range(0, NODE_COUNT), lim);
        if (find_free(target, rf, hit) && $urandom_range(9) != 0) begin
          n = hit;
          lvl = node_level(n);
          send_item(btfs_pkg::OP_ALLOC, n, $urandom_range(0, 15));
          while (lvl < target) begin
            n = 2 * n + $urandom_range(1, 2);
            lvl++;
            send_item(btfs_pkg::OP_ALLOC, n, $urandom_range(0, 15));
          end
        end
      end else if (pick < 60) begin
        start = $urandom_range(0, NODE_COUNT - 1);
        n = -1;
        for (int k = 0; k < NODE_COUNT && n < 0; k++) begin
          hit = (start + k) % NODE_COUNT;
          if (tree_bits[hit] && !node_set(2 * hit + 1) && !node_set(2 * hit + 2))
            n = hit;
        end
        if (n >= 0) begin
          send_item(btfs_pkg::OP_FREE, n, $urandom_range(0, 15));
          while (n > 0) begin
            parent = (n - 1) / 2;
            sib = (n % 2 == 1) ? n + 1 : n - 1;
            if (node_set(sib) || !node_set(parent)) break;
            send_item(btfs_pkg::OP_FREE, parent, $urandom_range(0, 15));
            n = parent;
          end
        end
      end else if (pick < 75) begin
        send_item(btfs_pkg::OP_QUERY, $urandom_range(0, NODE_COUNT), $urandom_range(0, 15));
      end else if (pick < 85) begin
        send_item(OP_W'($urandom_range(btfs_pkg::OP_SEARCH_L, btfs_pkg::OP_SEARCH_R)),
                  $urandom_range(0, NODE_COUNT), $urandom_range(0, 15));
      end else begin
        send_item(OP_W'($urandom_range(0, (1 << OP_W) - 1)), $urandom_range(0, NODE_COUNT),
                  $urandom_range(0, 15));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_buddy_traffic(23, 87, 580);
    test_buddy_traffic(87, 23, 580);
    test_buddy_traffic(0, 0, 560);
    in_tvalid <= 1'b0;
    rx_idle_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[buddy_tree_free_node_search] OK");
    end else begin
      $display("[buddy_tree_free_node_search] ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("[buddy_tree_free_node_search] ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/btfs_pkg.sv
rtl/core/btfs_ram.sv
rtl/core/btfs_node_alu.sv
rtl/core/buddy_tree_free_node_search.sv
rtl/core/btfs_checker.sv
tb/sv/tb.sv
